/* rtl/core/kch_pkg.sv */
// Shared types, constants and helpers of the k-mer counting histogram.
// Used by every module of the block; depends on nothing else.
package kch_pkg;

	localparam int K_MAX_DEF       = 8;
	localparam int COUNT_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CFG_INDEX_W     = 2;
	localparam int KMER_CODE_W     = 16;
	localparam int OUT_COUNT_W     = 32;
	localparam int KLEN_W          = 4;
	localparam int SEQ_POS_W       = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_KMER_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_ONLY = 2'd1;

	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_C_LO = 8'h63;
	localparam logic [7:0] CH_C_UP = 8'h43;
	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_T_LO = 8'h74;
	localparam logic [7:0] CH_T_UP = 8'h54;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;
	localparam logic [SEQ_POS_W-1:0] SEQ_POS_MAX = 4'd15;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  base_char;
		logic        end_of_sequence;
		logic [15:0] bin_index;
	} kch_item_t;

	typedef struct packed {
		logic        counted;
		logic [15:0] kmer_code;
		logic [31:0] bin_count;
		logic [31:0] sample_count;
		logic        bad_char;
	} kch_result_t;

	typedef struct packed {
		logic is_read;
		logic counted;
		logic bad;
	} kch_op_flags_t;

	// Returns {valid, two-bit base code}.
	function automatic logic [2:0] base_decode(input logic [7:0] ch);
		logic [2:0] res;
		case (ch)
			CH_A_LO, CH_A_UP: res = 3'b100;
			CH_C_LO, CH_C_UP: res = 3'b101;
			CH_G_LO, CH_G_UP: res = 3'b110;
			CH_T_LO, CH_T_UP: res = 3'b111;
			default:          res = 3'b000;
		endcase
		return res;
	endfunction

endpackage

/* rtl/core/kch_front.sv */
// Front end: configuration registers, base decoding and the sliding k-mer window.
// Classifies each request into a histogram operation. Depends on kch_pkg.
module kch_front import kch_pkg::*; #(
	parameter int K_MAX = K_MAX_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  kch_item_t                item,
	input  logic                     queue_full,
	input  logic                     clearing,
	output logic                     push,
	output kch_op_flags_t            push_flags,
	output logic [2*K_MAX-1:0]       push_code
);

	localparam int CODE_W = 2 * K_MAX;
	localparam int RUN_W  = $clog2(K_MAX + 1);
	localparam int IDX_W  = (CODE_W > KMER_CODE_W) ? CODE_W : KMER_CODE_W;

	logic [KLEN_W-1:0]    kmer_length_q;
	logic                 prefix_only_q;
	logic [CODE_W-1:0]    window_q;
	logic [RUN_W-1:0]     valid_run_q;
	logic [SEQ_POS_W-1:0] seq_pos_q;

	logic [KLEN_W-1:0]    k_eff;
	logic [2:0]           dec;
	logic [CODE_W-1:0]    window_next;
	logic [RUN_W-1:0]     run_next;
	logic [SEQ_POS_W-1:0] pos_next;
	logic [CODE_W-1:0]    kmask;
	logic [IDX_W-1:0]     idx_ext;
	logic                 take;
	logic                 accept;

	assign cfg_ready  = 1'b1;
	assign item_stall = queue_full | clearing;
	assign accept     = item_valid & ~item_stall;

	always_comb begin
		if (kmer_length_q == '0) begin
			k_eff = KLEN_W'(1);
		end else if (kmer_length_q > KLEN_W'(K_MAX)) begin
			k_eff = KLEN_W'(K_MAX);
		end else begin
			k_eff = kmer_length_q;
		end
		for (int i = 0; i < CODE_W; i++) begin
			kmask[i] = (i < 2 * int'(k_eff));
		end
	end

	always_comb begin
		dec         = base_decode(item.base_char);
		window_next = window_q;
		run_next    = '0;
		take        = 1'b0;
		if (dec[2]) begin
			window_next = (window_q << 2) | CODE_W'(dec[1:0]);
			run_next    = (valid_run_q < RUN_W'(K_MAX)) ? valid_run_q + 1'b1 : valid_run_q;
			take        = (KLEN_W'(run_next) >= k_eff)
				&& (!prefix_only_q || (seq_pos_q == SEQ_POS_W'(k_eff - 1'b1)));
		end
		pos_next = (seq_pos_q < SEQ_POS_MAX) ? seq_pos_q + 1'b1 : seq_pos_q;
		idx_ext  = IDX_W'(item.bin_index);
	end

	always_comb begin
		push               = accept;
		push_flags.is_read = (item.cmd == CMD_READ);
		push_flags.counted = (item.cmd == CMD_FEED) && take;
		push_flags.bad     = (item.cmd == CMD_FEED) && !dec[2];
		if (item.cmd == CMD_READ) begin
			push_code = idx_ext[CODE_W-1:0];
		end else if (take) begin
			push_code = window_next & kmask;
		end else begin
			push_code = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KLEN_RESET;
			prefix_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KMER_LENGTH: kmer_length_q <= cfg_data[KLEN_W-1:0];
				REG_PREFIX_ONLY: prefix_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			valid_run_q <= '0;
			seq_pos_q   <= '0;
		end else if (accept && item.cmd == CMD_FEED) begin
			if (item.end_of_sequence) begin
				window_q    <= '0;
				valid_run_q <= '0;
				seq_pos_q   <= '0;
			end else begin
				window_q    <= window_next;
				valid_run_q <= run_next;
				seq_pos_q   <= pos_next;
			end
		end
	end

endmodule

/* rtl/core/kch_queue.sv */
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on kch_pkg for its depth.
module kch_queue import kch_pkg::*; #(
	parameter int WIDTH = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/kch_back.sv */
// Back end: histogram memory with read-modify-write, clearing sweep and result register.
// Depends on kch_pkg.
module kch_back import kch_pkg::*; #(
	parameter int K_MAX      = K_MAX_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	input  kch_op_flags_t        op_flags,
	input  logic [2*K_MAX-1:0]   op_code,
	output logic                 op_pop,
	output logic                 clearing,
	output logic                 result_valid,
	input  logic                 result_stall,
	output kch_result_t          result
);

	localparam int CODE_W   = 2 * K_MAX;
	localparam int NUM_BINS = 1 << CODE_W;
	localparam int CW_EXT   = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
	localparam int KC_EXT   = (CODE_W > KMER_CODE_W) ? CODE_W : KMER_CODE_W;

	logic [COUNT_BITS-1:0] mem [NUM_BINS];

	logic                  clearing_q;
	logic [CODE_W-1:0]     clr_addr_q;
	logic                  valid_s1;
	kch_op_flags_t         flags_s1;
	logic [CODE_W-1:0]     code_s1;
	logic [COUNT_BITS-1:0] rd_s1;
	logic                  fwd_hit_s1;
	logic [COUNT_BITS-1:0] fwd_val_s1;
	logic [COUNT_BITS-1:0] total_q;
	logic                  result_valid_q;
	kch_result_t           result_q;

	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [COUNT_BITS-1:0] total_next;
	logic [COUNT_BITS-1:0] bin_val;
	logic [COUNT_BITS-1:0] total_val;
	logic [CW_EXT-1:0]     bin_ext;
	logic [CW_EXT-1:0]     total_ext;
	logic [KC_EXT-1:0]     code_ext;
	logic                  s1_adv;
	logic                  s1_load;
	logic                  mem_we;
	logic [CODE_W-1:0]     mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	assign clearing     = clearing_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		old_cnt    = fwd_hit_s1 ? fwd_val_s1 : rd_s1;
		new_cnt    = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
		total_next = (total_q == '1) ? total_q : total_q + 1'b1;
		s1_adv     = valid_s1 && (!result_valid_q || !result_stall);
		s1_load    = op_valid && !clearing_q && (!valid_s1 || s1_adv);
		op_pop     = s1_load;
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = s1_adv && flags_s1.counted;
			mem_waddr = code_s1;
			mem_wdata = new_cnt;
		end
		if (flags_s1.counted) begin
			bin_val = new_cnt;
		end else if (flags_s1.is_read) begin
			bin_val = old_cnt;
		end else begin
			bin_val = '0;
		end
		total_val = flags_s1.counted ? total_next : total_q;
		bin_ext   = CW_EXT'(bin_val);
		total_ext = CW_EXT'(total_val);
		code_ext  = KC_EXT'(code_s1);
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rd_s1 <= mem[op_code];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			flags_s1   <= op_flags;
			code_s1    <= op_code;
			fwd_hit_s1 <= s1_adv && flags_s1.counted && (code_s1 == op_code);
			fwd_val_s1 <= new_cnt;
		end
		if (s1_adv) begin
			result_q.counted      <= flags_s1.counted;
			result_q.kmer_code    <= code_ext[KMER_CODE_W-1:0];
			result_q.bin_count    <= bin_ext[OUT_COUNT_W-1:0];
			result_q.sample_count <= total_ext[OUT_COUNT_W-1:0];
			result_q.bad_char     <= flags_s1.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q     <= 1'b1;
			clr_addr_q     <= '0;
			valid_s1       <= 1'b0;
			total_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv && flags_s1.counted) begin
				total_q <= total_next;
			end
			if (s1_adv) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/kmer_count_histogram.sv */
// K-mer counting histogram: accepts sequence characters and bin reads, one result each.
// Holds the configuration port, front end, request queue and back end.
// Depends on kch_pkg, kch_front, kch_queue and kch_back.
//
// Requests enter on item_valid/item_stall as a kch_item_t: a feed request carries one
// character, a read request carries a bin index. Each request produces exactly one
// kch_result_t on result_valid/result_stall, in request order.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no request is outstanding.
// The front end decodes the base and updates the k-mer window in the accepting cycle
// and places the request in a four-entry queue. The back end reads the bin from the
// histogram memory, adds one with saturation, writes it back and registers the result.
// From acceptance a request passes the queue slot, the read stage and the result register.
// Throughput is one request per cycle while the result is not stalled, set by the single
// read and write port of the histogram memory; equal codes in back-to-back requests are
// forwarded. After reset the memory is swept to zero one bin per cycle, all 4**K_MAX bins
// (65536 at the default), while item_stall stays high.
// When result_stall is high the result holds; the back end then stops taking requests,
// the queue fills and item_stall rises once the queue is full.
module kmer_count_histogram import kch_pkg::*; #(
	parameter int K_MAX      = K_MAX_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  kch_item_t              item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output kch_result_t            result
);

	localparam int CODE_W = 2 * K_MAX;
	localparam int OP_W   = $bits(kch_op_flags_t) + CODE_W;

	logic              queue_full;
	logic              clearing;
	logic              push;
	kch_op_flags_t     push_flags;
	logic [CODE_W-1:0] push_code;
	logic              pop;
	logic              q_not_empty;
	logic [OP_W-1:0]   q_head;
	kch_op_flags_t     head_flags;
	logic [CODE_W-1:0] head_code;

	assign head_flags = q_head[OP_W-1:CODE_W];
	assign head_code  = q_head[CODE_W-1:0];

	kch_front #(
		.K_MAX(K_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.clearing   (clearing),
		.push       (push),
		.push_flags (push_flags),
		.push_code  (push_code)
	);

	kch_queue #(
		.WIDTH(OP_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_code}),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	kch_back #(
		.K_MAX      (K_MAX),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (q_not_empty),
		.op_flags     (head_flags),
		.op_code      (head_code),
		.op_pop       (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* rtl/core/kch_checker.sv */
// Port-level checks on the result channel of the k-mer counting histogram.
// Depends on kch_pkg; bound to kmer_count_histogram at the end of this file.
module kch_checker import kch_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input kch_result_t result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("Result valid dropped while stalled.");

	a_bad_not_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_char |->
			!result.counted && result.kmer_code == '0 && result.bin_count == '0)
		else $error("Bad character produced a count.");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.counted |->
			result.bin_count != '0 && result.sample_count != '0)
		else $error("Counted k-mer shows a zero count.");

	a_bin_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.counted |-> result.sample_count >= result.bin_count)
		else $error("Bin count exceeds the sample total.");

endmodule

bind kmer_count_histogram kch_checker u_kch_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* tb/tb_kmer_count_histogram.sv */
`timescale 1ns / 1ps
// Self-checking testbench for kmer_count_histogram: feeds sequence characters and bin reads,
// predicts every result in step with the accepted requests and compares them field by field.
// Depends on kch_pkg and the kmer_count_histogram RTL.
module tb_kmer_count_histogram;
	import kch_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data = '0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	kch_item_t              item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	kch_result_t            result;

	kmer_count_histogram DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	kch_item_t   request_q[$];
	kch_result_t pending_results[$];
	int          requests_queued = 0;
	int          requests_taken = 0;
	bit          request_taken = 1'b0;
	int          fail_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_req = 0;
	int          hold_left = 0;
	logic [15:0] rd_mask = 16'h00FF;

	logic [3:0]  cfg_klen = KLEN_RESET;
	logic        cfg_prefix = 1'b0;
	logic [15:0] win_bases = '0;
	logic [3:0]  run_len = '0;
	logic [3:0]  seq_pos = '0;
	logic [31:0] bin_counts[logic [15:0]];
	logic [31:0] kmer_total = '0;

	function automatic kch_result_t count_kmer(input kch_item_t it);
		kch_result_t r;
		int k;
		int bval;
		logic [15:0] kmask;
		logic [15:0] code;
		logic [31:0] cnt;
		r = '0;
		if (it.cmd == CMD_READ) begin
			r.kmer_code = it.bin_index;
			r.bin_count = bin_counts.exists(it.bin_index) ? bin_counts[it.bin_index] : 32'd0;
			r.sample_count = kmer_total;
			return r;
		end
		k = cfg_klen;
		if (k < 1) k = 1;
		if (k > K_MAX_DEF) k = K_MAX_DEF;
		kmask = 16'((32'd1 << (2 * k)) - 1);
		case (it.base_char)
			CH_A_LO, CH_A_UP: bval = 0;
			CH_C_LO, CH_C_UP: bval = 1;
			CH_G_LO, CH_G_UP: bval = 2;
			CH_T_LO, CH_T_UP: bval = 3;
			default:          bval = -1;
		endcase
		if (bval < 0) begin
			r.bad_char = 1'b1;
			run_len = '0;
		end else begin
			win_bases = {win_bases[13:0], 2'(bval)};
			if (run_len < K_MAX_DEF) run_len++;
			if (run_len >= k && (!cfg_prefix || seq_pos == k - 1)) begin
				code = win_bases & kmask;
				cnt = bin_counts.exists(code) ? bin_counts[code] : 32'd0;
				if (cnt != '1) cnt++;
				bin_counts[code] = cnt;
				if (kmer_total != '1) kmer_total++;
				r.counted = 1'b1;
				r.kmer_code = code;
				r.bin_count = cnt;
			end
		end
		if (seq_pos < SEQ_POS_MAX) seq_pos++;
		if (it.end_of_sequence) begin
			win_bases = '0;
			run_len = '0;
			seq_pos = '0;
		end
		r.sample_count = kmer_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(negedge clk) begin : item_source
		if (arst_n && (!item_valid || request_taken)) begin
			request_taken = 1'b0;
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= request_q.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : item_accept
		if (arst_n && item_valid && !item_stall) begin
			pending_results.push_back(count_kmer(item));
			requests_taken++;
			request_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : result_sink
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (hold_req > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_req - 1;
			hold_req = 0;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		kch_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("counted", 32'(want.counted), 32'(result.counted));
				check_field("kmer_code", 32'(want.kmer_code), 32'(result.kmer_code));
				check_field("bin_count", want.bin_count, result.bin_count);
				check_field("sample_count", want.sample_count, result.sample_count);
				check_field("bad_char", 32'(want.bad_char), 32'(result.bad_char));
			end
		end
	end

	task automatic queue_item(input logic op, input logic [7:0] ch, input logic eos,
			input logic [15:0] idx);
		kch_item_t it;
		it.cmd = op;
		it.base_char = ch;
		it.end_of_sequence = eos;
		it.bin_index = idx;
		request_q.push_back(it);
		requests_queued++;
	endtask

	function automatic logic [7:0] random_base();
		logic [7:0] ch;
		case ($urandom_range(3))
			0:       ch = CH_A_LO;
			1:       ch = CH_C_LO;
			2:       ch = CH_G_LO;
			default: ch = CH_T_LO;
		endcase
		if ($urandom_range(1)) ch = ch & 8'hDF;
		return ch;
	endfunction

	task automatic queue_sequence();
		int len;
		bit homo;
		logic [7:0] home;
		logic [7:0] ch;
		logic [15:0] idx;
		len = $urandom_range(1, 20);
		homo = ($urandom_range(4) == 0);
		home = random_base();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) ch = 8'($urandom);
			else if (homo) ch = home;
			else ch = random_base();
			queue_item(CMD_FEED, ch, i == len - 1, 16'($urandom));
			if ($urandom_range(9) == 0) begin
				idx = 16'($urandom);
				if ($urandom_range(3) != 0) idx &= rd_mask;
				queue_item(CMD_READ, 8'($urandom), 1'($urandom), idx);
			end
		end
	endtask

	task automatic wait_idle();
		while (requests_taken != requests_queued || pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KMER_LENGTH: cfg_klen = val[3:0];
			REG_PREFIX_ONLY: cfg_prefix = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	logic [31:0] klen_tab[9] = '{32'd1, 32'd8, 32'd3, 32'h15, 32'd15, 32'd0, 32'd2, 32'd9, 32'd6};
	logic        prefix_tab[9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

	initial begin : stimulus
		int mark;
		int keff;
		bit paused;
		send_idle_pct = 19;
		recv_idle_pct = 57;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_item(CMD_FEED, CH_A_UP, 1'b0, 16'hFFFF);
		queue_item(CMD_FEED, CH_C_UP, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_G_UP, 1'b0, 16'hFFFF);
		queue_item(CMD_FEED, CH_T_UP, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_A_LO, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_C_LO, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_G_LO, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_T_LO, 1'b0, 16'h0000);
		queue_item(CMD_FEED, 8'h00, 1'b0, 16'h0000);
		queue_item(CMD_FEED, 8'hFF, 1'b0, 16'h0000);
		queue_item(CMD_FEED, 8'h4E, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_G_LO, 1'b1, 16'h0000);
		queue_item(CMD_READ, 8'hFF, 1'b1, 16'h001B);
		queue_item(CMD_READ, 8'h00, 1'b0, 16'hFFFF);
		queue_item(CMD_READ, 8'h00, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_A_UP, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_C_UP, 1'b0, 16'h0000);
		wait_idle();

		// The window and run built under k = 4 carry over into k = 2.
		write_reg(REG_KMER_LENGTH, 32'd2);
		queue_item(CMD_FEED, CH_G_UP, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_T_UP, 1'b1, 16'h0000);
		wait_idle();

		write_reg(REG_KMER_LENGTH, 32'd0);
		write_reg(REG_PREFIX_ONLY, 32'd1);
		queue_item(CMD_FEED, CH_T_LO, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_A_LO, 1'b1, 16'h0000);
		queue_item(CMD_READ, 8'h00, 1'b0, 16'h0003);
		wait_idle();

		write_reg(REG_KMER_LENGTH, 32'd15);
		queue_item(CMD_FEED, CH_A_UP, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_C_UP, 1'b0, 16'h0000);
		queue_item(CMD_FEED, CH_G_UP, 1'b1, 16'h0000);
		wait_idle();

		for (int ph = 0; ph < 9; ph++) begin
			send_idle_pct = (ph < 3) ? 19 : (ph < 6) ? 57 : 0;
			recv_idle_pct = (ph < 3) ? 57 : (ph < 6) ? 19 : 0;
			write_reg(REG_KMER_LENGTH, klen_tab[ph]);
			write_reg(REG_PREFIX_ONLY, {31'($urandom), prefix_tab[ph]});
			keff = klen_tab[ph][3:0];
			if (keff < 1) keff = 1;
			if (keff > K_MAX_DEF) keff = K_MAX_DEF;
			rd_mask = 16'((32'd1 << (2 * keff)) - 1);
			// A long result stall lets the queue fill up and push back on requests.
			if (ph == 1 || ph == 6) hold_req = 150 + $urandom_range(50);
			mark = requests_queued;
			paused = 1'b0;
			while (requests_queued - mark < 190) begin
				if (!paused && requests_queued - mark >= 95) begin
					wait_idle();
					paused = 1'b1;
				end
				if ($urandom_range(19) == 0)
					queue_item(1'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
				else queue_sequence();
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/kch_pkg.sv
rtl/core/kch_front.sv
rtl/core/kch_queue.sv
rtl/core/kch_back.sv
rtl/core/kmer_count_histogram.sv
rtl/core/kch_checker.sv
tb/tb_kmer_count_histogram.sv
